[rtl/dsa_pkg.sv]
// Shared types and constants for the descriptor slot allocator.
package dsa_pkg;

	localparam int MAX_TRANSIENT    = 4096;
	localparam int FRAMES_IN_FLIGHT = 3;

	localparam int PCNT_W   = 11;
	localparam int TCNT_W   = 13;
	localparam int STRIDE_W = 13;
	localparam int ADDR_W   = 64;
	localparam int SLOT_W   = 16;
	localparam int FRAME_W  = 3;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = 17;
	localparam int OFF_W    = IDX_W + STRIDE_W;
	localparam int CIDX_W   = 3;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 160;

	localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
	localparam logic [OP_W-1:0] OP_BEGIN     = 3'd2;
	localparam logic [OP_W-1:0] OP_TRANSIENT = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;

	localparam logic [CIDX_W-1:0] REG_PCOUNT = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TCOUNT = 3'd1;
	localparam logic [CIDX_W-1:0] REG_STRIDE = 3'd2;
	localparam logic [CIDX_W-1:0] REG_CPU    = 3'd3;
	localparam logic [CIDX_W-1:0] REG_GPU    = 3'd4;

	localparam logic [SLOT_W-1:0] NO_INDEX = 16'hFFFF;

	typedef struct packed {
		logic accept;
		logic exec;
		logic mul;
		logic load_out;
	} cmd_t;

endpackage

[rtl/dsa_ctrl.sv]
// Sequencing controller: walks one request through decide, multiply and address stages.
module dsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dsa_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		MUL,
		ADD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.accept   = (state_q == IDLE) && in_valid;
		cmd.exec     = (state_q == EXEC);
		cmd.mul      = (state_q == MUL);
		cmd.load_out = (state_q == ADD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= EXEC;
				end
				EXEC: state_q <= MUL;
				MUL:  state_q <= ADD;
				ADD: begin
					if (out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/dsa_dpath.sv]
// Allocator datapath: registers, counters, free stack memory and address arithmetic.
module dsa_dpath #(
	parameter int MAX_PERSISTENT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dsa_pkg::cmd_t                     cmd,
	input  logic [dsa_pkg::OP_W-1:0]          opcode,
	input  logic [dsa_pkg::SLOT_W-1:0]        slot_index,
	input  logic [dsa_pkg::FRAME_W-1:0]       frame_number,
	input  logic [dsa_pkg::TCNT_W-1:0]        run_length,
	input  logic                              cfg_we,
	input  logic [dsa_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [dsa_pkg::ADDR_W-1:0]        cfg_data,
	output logic [dsa_pkg::STAT_W-1:0]        status,
	output logic [dsa_pkg::SLOT_W-1:0]        granted_index,
	output logic [dsa_pkg::ADDR_W-1:0]        cpu_address,
	output logic [dsa_pkg::ADDR_W-1:0]        gpu_address,
	output logic [dsa_pkg::PCNT_W-1:0]        persistent_live
);

	// The 11-bit count register can never ask for more than 2047 slots.
	localparam int STACK_DEPTH = (MAX_PERSISTENT < 2047) ? MAX_PERSISTENT : 2047;
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int PW = dsa_pkg::PCNT_W;
	localparam int TW = dsa_pkg::TCNT_W;

	// configuration
	logic [PW-1:0]                     pcount_q;
	logic [TW-1:0]                     tcount_q;
	logic [dsa_pkg::STRIDE_W-1:0]      stride_q;
	logic [dsa_pkg::ADDR_W-1:0]        cpu_base_q;
	logic [dsa_pkg::ADDR_W-1:0]        gpu_base_q;

	// captured request
	logic [dsa_pkg::OP_W-1:0]          op_q;
	logic [dsa_pkg::SLOT_W-1:0]        slot_q;
	logic [dsa_pkg::FRAME_W-1:0]       frame_q;
	logic [TW-1:0]                     run_q;

	// allocator state
	logic [PW-1:0]                     depth_q;
	logic [PW-1:0]                     hwater_q;
	logic [PW-1:0]                     live_q;
	logic [TW-1:0]                     used_q;
	logic [dsa_pkg::FRAME_W-1:0]       cur_frame_q;

	// free stack
	logic [IW-1:0]                     stack_mem [STACK_DEPTH];
	logic [IW-1:0]                     rd_data_q;
	logic [PW-1:0]                     rd_ptr;
	logic                              push;

	// pipeline
	logic [dsa_pkg::IDX_W-1:0]         idx_s1;
	logic                              grant_s1;
	logic [dsa_pkg::STAT_W-1:0]        stat_s1;
	logic [PW-1:0]                     live_s1;
	logic [dsa_pkg::OFF_W-1:0]         off_s2;
	logic                              grant_s2;
	logic [dsa_pkg::STAT_W-1:0]        stat_s2;
	logic [PW-1:0]                     live_s2;
	logic [dsa_pkg::SLOT_W-1:0]        gidx_s2;

	// output
	logic [dsa_pkg::STAT_W-1:0]        status_q;
	logic [dsa_pkg::SLOT_W-1:0]        gidx_q;
	logic [dsa_pkg::ADDR_W-1:0]        cpu_q;
	logic [dsa_pkg::ADDR_W-1:0]        gpu_q;
	logic [PW-1:0]                     live_out_q;

	// decide stage
	logic [PW-1:0]                     pc_eff;
	logic [TW-1:0]                     tc_eff;
	logic [PW-1:0]                     depth_n;
	logic [PW-1:0]                     hwater_n;
	logic [PW-1:0]                     live_n;
	logic [TW-1:0]                     used_n;
	logic [dsa_pkg::FRAME_W-1:0]       frame_n;
	logic [dsa_pkg::IDX_W-1:0]         idx_n;
	logic                              grant_n;
	logic [dsa_pkg::STAT_W-1:0]        stat_n;
	logic [TW:0]                       run_end;
	logic [dsa_pkg::IDX_W-1:0]         region_base;

	assign pc_eff = (pcount_q > PW'(STACK_DEPTH)) ? PW'(STACK_DEPTH) : pcount_q;
	assign tc_eff = (tcount_q > TW'(dsa_pkg::MAX_TRANSIENT)) ?
		TW'(dsa_pkg::MAX_TRANSIENT) : tcount_q;
	assign rd_ptr  = depth_q - PW'(1);
	assign run_end = {1'b0, used_q} + {1'b0, run_q};
	assign region_base = dsa_pkg::IDX_W'(pc_eff)
		+ dsa_pkg::IDX_W'(cur_frame_q) * dsa_pkg::IDX_W'(tc_eff);

	always_comb begin
		depth_n  = depth_q;
		hwater_n = hwater_q;
		live_n   = live_q;
		used_n   = used_q;
		frame_n  = cur_frame_q;
		idx_n    = '0;
		grant_n  = 1'b0;
		stat_n   = dsa_pkg::ST_OK;
		push     = 1'b0;
		unique case (op_q)
			dsa_pkg::OP_ALLOC: begin
				if (depth_q != '0) begin
					depth_n = depth_q - PW'(1);
					idx_n   = dsa_pkg::IDX_W'(rd_data_q);
					live_n  = live_q + PW'(1);
					grant_n = 1'b1;
				end else if (hwater_q < pc_eff) begin
					idx_n    = dsa_pkg::IDX_W'(hwater_q);
					hwater_n = hwater_q + PW'(1);
					live_n   = live_q + PW'(1);
					grant_n  = 1'b1;
				end else begin
					stat_n = dsa_pkg::ST_EXHAUSTED;
				end
			end
			dsa_pkg::OP_FREE: begin
				if (slot_q == dsa_pkg::NO_INDEX) begin
					stat_n = dsa_pkg::ST_OK;
				end else if (slot_q >= dsa_pkg::SLOT_W'(pc_eff) || live_q == '0) begin
					stat_n = dsa_pkg::ST_INVALID;
				end else begin
					push    = 1'b1;
					depth_n = depth_q + PW'(1);
					live_n  = live_q - PW'(1);
				end
			end
			dsa_pkg::OP_BEGIN: begin
				if ({1'b0, frame_q} >= 4'(dsa_pkg::FRAMES_IN_FLIGHT)) begin
					stat_n = dsa_pkg::ST_INVALID;
				end else begin
					frame_n = frame_q;
					used_n  = '0;
				end
			end
			dsa_pkg::OP_TRANSIENT: begin
				if (run_q == '0) begin
					stat_n = dsa_pkg::ST_INVALID;
				end else if (run_end > {1'b0, tc_eff}) begin
					stat_n = dsa_pkg::ST_EXHAUSTED;
				end else begin
					idx_n   = region_base + dsa_pkg::IDX_W'(used_q);
					used_n  = run_end[TW-1:0];
					grant_n = 1'b1;
				end
			end
			dsa_pkg::OP_CLEAR: begin
				depth_n  = '0;
				hwater_n = '0;
				live_n   = '0;
				used_n   = '0;
				frame_n  = '0;
			end
			default: stat_n = dsa_pkg::ST_INVALID;
		endcase
	end

	// configuration registers and allocator counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q    <= '0;
			tcount_q    <= '0;
			stride_q    <= '0;
			cpu_base_q  <= '0;
			gpu_base_q  <= '0;
			depth_q     <= '0;
			hwater_q    <= '0;
			live_q      <= '0;
			used_q      <= '0;
			cur_frame_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dsa_pkg::REG_PCOUNT: pcount_q   <= cfg_data[PW-1:0];
					dsa_pkg::REG_TCOUNT: tcount_q   <= cfg_data[TW-1:0];
					dsa_pkg::REG_STRIDE: stride_q   <= cfg_data[dsa_pkg::STRIDE_W-1:0];
					dsa_pkg::REG_CPU:    cpu_base_q <= cfg_data;
					dsa_pkg::REG_GPU:    gpu_base_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				depth_q     <= depth_n;
				hwater_q    <= hwater_n;
				live_q      <= live_n;
				used_q      <= used_n;
				cur_frame_q <= frame_n;
			end
		end
	end

	// free stack: read the top on accept, push during decide
	always_ff @(posedge clk) begin
		if (cmd.accept) rd_data_q <= stack_mem[rd_ptr[IW-1:0]];
		if (cmd.exec && push) stack_mem[depth_q[IW-1:0]] <= slot_q[IW-1:0];
	end

	// request capture and pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode;
			slot_q  <= slot_index;
			frame_q <= frame_number;
			run_q   <= run_length;
		end
		if (cmd.exec) begin
			idx_s1   <= idx_n;
			grant_s1 <= grant_n;
			stat_s1  <= stat_n;
			live_s1  <= live_n;
		end
		if (cmd.mul) begin
			off_s2   <= {{dsa_pkg::STRIDE_W{1'b0}}, idx_s1}
				* {{dsa_pkg::IDX_W{1'b0}}, stride_q};
			grant_s2 <= grant_s1;
			stat_s2  <= stat_s1;
			live_s2  <= live_s1;
			gidx_s2  <= grant_s1 ? idx_s1[dsa_pkg::SLOT_W-1:0] : dsa_pkg::NO_INDEX;
		end
		if (cmd.load_out) begin
			status_q   <= stat_s2;
			gidx_q     <= gidx_s2;
			live_out_q <= live_s2;
			cpu_q      <= grant_s2 ?
				cpu_base_q + dsa_pkg::ADDR_W'(off_s2) : '0;
			gpu_q      <= (grant_s2 && gpu_base_q != '0) ?
				gpu_base_q + dsa_pkg::ADDR_W'(off_s2) : '0;
		end
	end

	assign status          = status_q;
	assign granted_index   = gidx_q;
	assign cpu_address     = cpu_q;
	assign gpu_address     = gpu_q;
	assign persistent_live = live_out_q;

endmodule

[rtl/descriptor_slot_allocator.sv]
// Top level of the descriptor slot allocator.
//
// Request stream s_*: one beat per command. s_tuser carries the opcode
// (allocate, free, begin frame, allocate transient, clear); s_tdata carries
// slot_index, frame_number and run_length. Every request beat yields exactly
// one response beat on m_*: status in m_tuser, then granted index, host
// address, device address and the live persistent count in m_tdata.
// Configuration writes arrive on cfg_* (index 0 persistent count, 1 transient
// slots per frame, 2 slot stride, 3 host base, 4 device base); cfg_ready is
// always high, and writes are expected only while no request is in progress.
// A request walks through a free-stack memory read, the decision
// stage, the index-times-stride multiply and the wide address add. The read
// happens at the accepting edge, and a new request is taken only once the
// current one has left the add stage. The response register lets the next
// request enter while the previous response waits; if the receiver holds
// m_tready low the new request stalls in its final stage until the
// register empties.
// Reset clears all counters and configuration registers; free-stack contents
// are left as they are and are only used after being written.
module descriptor_slot_allocator #(
	parameter int MAX_PERSISTENT = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [15:0] slot_index, [18:16] frame_number, [31:19] run_length
	input  logic [dsa_pkg::S_TDATA_W-1:0]        s_tdata,
	// [2:0] opcode
	input  logic [dsa_pkg::OP_W-1:0]             s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [15:0] granted_index, [79:16] cpu_address, [143:80] gpu_address,
	// [154:144] persistent_live, [159:155] zero
	output logic [dsa_pkg::M_TDATA_W-1:0]        m_tdata,
	// [1:0] status
	output logic [dsa_pkg::STAT_W-1:0]           m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dsa_pkg::CIDX_W-1:0]           cfg_index,
	input  logic [dsa_pkg::ADDR_W-1:0]           cfg_data
);

	dsa_pkg::cmd_t                    cmd;
	logic [dsa_pkg::SLOT_W-1:0]       granted_index;
	logic [dsa_pkg::ADDR_W-1:0]       cpu_address;
	logic [dsa_pkg::ADDR_W-1:0]       gpu_address;
	logic [dsa_pkg::PCNT_W-1:0]       persistent_live;

	assign cfg_ready = 1'b1;

	dsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	dsa_dpath #(
		.MAX_PERSISTENT (MAX_PERSISTENT)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.opcode          (s_tuser),
		.slot_index      (s_tdata[15:0]),
		.frame_number    (s_tdata[18:16]),
		.run_length      (s_tdata[31:19]),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.status          (m_tuser),
		.granted_index   (granted_index),
		.cpu_address     (cpu_address),
		.gpu_address     (gpu_address),
		.persistent_live (persistent_live)
	);

	assign m_tdata = {5'b0, persistent_live, gpu_address, cpu_address, granted_index};

endmodule

[rtl/dsa_checker.sv]
// Port-level checks for the descriptor slot allocator, bound to the top level.
module dsa_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [dsa_pkg::M_TDATA_W-1:0]        m_tdata,
	input logic [dsa_pkg::STAT_W-1:0]           m_tuser
);

	// hold a stalled response beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("response beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("response payload changed while stalled");

	// one request in flight: no new request beat right after one is taken
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

	// a refusal carries no grant
	a_refusal_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != dsa_pkg::ST_OK |->
			m_tdata[15:0] == dsa_pkg::NO_INDEX && m_tdata[143:16] == '0)
		else $error("refused request reports a grant");

	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == dsa_pkg::ST_OK || m_tuser == dsa_pkg::ST_EXHAUSTED
			|| m_tuser == dsa_pkg::ST_INVALID)
		else $error("undefined status code");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/sv/descriptor_slot_allocator_test.sv]
// Self-checking testbench: directed and random command streams against a slot allocation predictor.
`timescale 1ns / 100ps

module descriptor_slot_allocator_test;

	localparam int MAX_PERSISTENT = 1024;
	localparam int STALL_LIMIT = 3000;
	localparam int BACKPRESSURE_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam logic [dsa_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [dsa_pkg::OP_W-1:0] OP_RESERVED_LAST = {dsa_pkg::OP_W{1'b1}};

	typedef struct packed {
		logic [dsa_pkg::OP_W-1:0]    op;
		logic [dsa_pkg::SLOT_W-1:0]  slot;
		logic [dsa_pkg::FRAME_W-1:0] frame;
		logic [dsa_pkg::TCNT_W-1:0]  run;
	} request_t;

	typedef struct packed {
		logic [dsa_pkg::STAT_W-1:0] status;
		logic [dsa_pkg::SLOT_W-1:0] index;
		logic [dsa_pkg::ADDR_W-1:0] cpu;
		logic [dsa_pkg::ADDR_W-1:0] gpu;
		logic [dsa_pkg::PCNT_W-1:0] live;
	} grant_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [dsa_pkg::S_TDATA_W-1:0] s_tdata;
	logic [dsa_pkg::OP_W-1:0]      s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [dsa_pkg::M_TDATA_W-1:0] m_tdata;
	logic [dsa_pkg::STAT_W-1:0]    m_tuser;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [dsa_pkg::CIDX_W-1:0]    cfg_index;
	logic [dsa_pkg::ADDR_W-1:0]    cfg_data;

	descriptor_slot_allocator #(
		.MAX_PERSISTENT(MAX_PERSISTENT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow registers and allocator state
	logic [dsa_pkg::PCNT_W-1:0]   pcount_reg = '0;
	logic [dsa_pkg::TCNT_W-1:0]   tcount_reg = '0;
	logic [dsa_pkg::STRIDE_W-1:0] stride_reg = '0;
	logic [dsa_pkg::ADDR_W-1:0]   cpu_base_reg = '0;
	logic [dsa_pkg::ADDR_W-1:0]   gpu_base_reg = '0;
	logic [dsa_pkg::SLOT_W-1:0]   free_stack [MAX_PERSISTENT];
	int unsigned                  free_depth = 0;
	int unsigned                  high_water = 0;
	int unsigned                  live_count = 0;
	int unsigned                  transient_used = 0;
	int unsigned                  current_frame = 0;

	grant_t                     pending_grants [$];
	logic [dsa_pkg::SLOT_W-1:0] live_slots [$];
	int                         mismatch_count = 0;
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	int                         stall_request = 0;
	bit                         offering = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned persistent_slots();
		return (pcount_reg > MAX_PERSISTENT) ? MAX_PERSISTENT : 32'(pcount_reg);
	endfunction

	function automatic int unsigned transient_slots();
		return (tcount_reg > dsa_pkg::MAX_TRANSIENT) ? dsa_pkg::MAX_TRANSIENT : 32'(tcount_reg);
	endfunction

	function automatic grant_t compute_grant(request_t r);
		grant_t                     g;
		logic [dsa_pkg::ADDR_W-1:0] idx;
		logic [dsa_pkg::ADDR_W-1:0] stride;
		logic [dsa_pkg::ADDR_W-1:0] offset;
		bit                         granted;
		int unsigned                pc;
		int unsigned                tc;
		pc = persistent_slots();
		tc = transient_slots();
		granted = 1'b0;
		idx = '0;
		g.status = dsa_pkg::ST_OK;
		case (r.op)
			dsa_pkg::OP_ALLOC: begin
				if (free_depth > 0) begin
					free_depth--;
					idx = dsa_pkg::ADDR_W'(free_stack[free_depth]);
					granted = 1'b1;
				end else if (high_water < pc) begin
					idx = dsa_pkg::ADDR_W'(high_water);
					high_water++;
					granted = 1'b1;
				end else begin
					g.status = dsa_pkg::ST_EXHAUSTED;
				end
				if (granted)
					live_count++;
			end
			dsa_pkg::OP_FREE: begin
				if (r.slot == dsa_pkg::NO_INDEX) begin
					g.status = dsa_pkg::ST_OK;
				end else if (r.slot >= pc || live_count == 0 ||
						free_depth >= MAX_PERSISTENT) begin
					g.status = dsa_pkg::ST_INVALID;
				end else begin
					free_stack[free_depth] = r.slot;
					free_depth++;
					live_count--;
				end
			end
			dsa_pkg::OP_BEGIN: begin
				if (r.frame >= dsa_pkg::FRAMES_IN_FLIGHT) begin
					g.status = dsa_pkg::ST_INVALID;
				end else begin
					current_frame = 32'(r.frame);
					transient_used = 0;
				end
			end
			dsa_pkg::OP_TRANSIENT: begin
				if (r.run == 0) begin
					g.status = dsa_pkg::ST_INVALID;
				end else if (transient_used + r.run > tc) begin
					g.status = dsa_pkg::ST_EXHAUSTED;
				end else begin
					idx = dsa_pkg::ADDR_W'(pc + current_frame * tc + transient_used);
					transient_used += r.run;
					granted = 1'b1;
				end
			end
			dsa_pkg::OP_CLEAR: begin
				free_depth = 0;
				high_water = 0;
				live_count = 0;
				transient_used = 0;
				current_frame = 0;
			end
			default: g.status = dsa_pkg::ST_INVALID;
		endcase
		stride = dsa_pkg::ADDR_W'(stride_reg);
		offset = idx * stride;
		g.index = granted ? idx[dsa_pkg::SLOT_W-1:0] : dsa_pkg::NO_INDEX;
		g.cpu = granted ? cpu_base_reg + offset : '0;
		g.gpu = (granted && gpu_base_reg != 0) ? gpu_base_reg + offset : '0;
		g.live = live_count[dsa_pkg::PCNT_W-1:0];
		return g;
	endfunction

	function automatic void flag_mismatch(string what, logic [dsa_pkg::ADDR_W-1:0] want,
			logic [dsa_pkg::ADDR_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endfunction

	task automatic stop_offer();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send_request(request_t r);
		grant_t g;
		if ($urandom_range(99) < send_idle_pct) begin
			stop_offer();
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		offering = 1'b1;
		s_tuser <= r.op;
		s_tdata <= {r.run, r.frame, r.slot};
		do @(posedge clk); while (!s_tready);
		g = compute_grant(r);
		pending_grants.insert(pending_grants.size(), g);
		if (r.op == dsa_pkg::OP_ALLOC && g.status == dsa_pkg::ST_OK)
			live_slots.insert(live_slots.size(), g.index);
		if (r.op == dsa_pkg::OP_CLEAR)
			live_slots.delete();
	endtask

	task automatic send_op(logic [dsa_pkg::OP_W-1:0] op, int unsigned slot = 0,
			int unsigned frame = 0, int unsigned run = 0);
		request_t r;
		r.op = op;
		r.slot = dsa_pkg::SLOT_W'(slot);
		r.frame = dsa_pkg::FRAME_W'(frame);
		r.run = dsa_pkg::TCNT_W'(run);
		send_request(r);
	endtask

	// Write all registers; only with the allocator drained.
	task automatic load_config(int unsigned pc, int unsigned tc, int unsigned stride,
			logic [dsa_pkg::ADDR_W-1:0] cpu, logic [dsa_pkg::ADDR_W-1:0] gpu);
		logic [dsa_pkg::CIDX_W-1:0] order [5];
		logic [dsa_pkg::ADDR_W-1:0] vals [5];
		order = '{dsa_pkg::REG_PCOUNT, dsa_pkg::REG_TCOUNT, dsa_pkg::REG_STRIDE,
			dsa_pkg::REG_CPU, dsa_pkg::REG_GPU};
		vals = '{dsa_pkg::ADDR_W'(pc), dsa_pkg::ADDR_W'(tc), dsa_pkg::ADDR_W'(stride), cpu, gpu};
		stop_offer();
		while (pending_grants.size() != 0) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (order[i])
				dsa_pkg::REG_PCOUNT: pcount_reg = vals[i][dsa_pkg::PCNT_W-1:0];
				dsa_pkg::REG_TCOUNT: tcount_reg = vals[i][dsa_pkg::TCNT_W-1:0];
				dsa_pkg::REG_STRIDE: stride_reg = vals[i][dsa_pkg::STRIDE_W-1:0];
				dsa_pkg::REG_CPU:    cpu_base_reg = vals[i];
				dsa_pkg::REG_GPU:    gpu_base_reg = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: frees of live slots, runs that fit, valid frames.
	task automatic make_random_request(output request_t r);
		int          pick;
		int          k;
		int unsigned room;
		r.op = dsa_pkg::OP_ALLOC;
		r.slot = dsa_pkg::SLOT_W'($urandom);
		r.frame = dsa_pkg::FRAME_W'($urandom);
		r.run = dsa_pkg::TCNT_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 32) begin
			r.op = dsa_pkg::OP_ALLOC;
		end else if (pick < 57) begin
			r.op = dsa_pkg::OP_FREE;
			if (live_slots.size() != 0) begin
				k = $urandom_range(live_slots.size() - 1);
				r.slot = live_slots[k];
				live_slots.delete(k);
			end
		end else if (pick < 62) begin
			r.op = dsa_pkg::OP_FREE;
			case ($urandom_range(2))
				0: r.slot = dsa_pkg::NO_INDEX;
				1: r.slot = dsa_pkg::SLOT_W'($urandom_range(0, 31));
				default: ;
			endcase
		end else if (pick < 72) begin
			r.op = dsa_pkg::OP_BEGIN;
			if ($urandom_range(4) != 0)
				r.frame = dsa_pkg::FRAME_W'($urandom_range(0, dsa_pkg::FRAMES_IN_FLIGHT - 1));
		end else if (pick < 92) begin
			r.op = dsa_pkg::OP_TRANSIENT;
			room = transient_slots() - transient_used;
			if (room > 0 && $urandom_range(3) != 0)
				r.run = dsa_pkg::TCNT_W'($urandom_range(1, (room < 24) ? room : 24));
		end else if (pick < 95) begin
			r.op = dsa_pkg::OP_CLEAR;
		end else if (pick < 98) begin
			r.op = dsa_pkg::OP_W'($urandom);
		end else begin
			r.op = dsa_pkg::OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
		end
	endtask

	task automatic test_reset_defaults();
		// every register is zero: nothing can be granted
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_TRANSIENT, 0, 0, 1);
		send_op(dsa_pkg::OP_BEGIN, 0, 0);
		send_op(dsa_pkg::OP_FREE, 0);
	endtask

	task automatic test_persistent_stack();
		load_config(4, 8, 4096, 64'hFFFF_FFFF_FFFF_F000, 64'h0);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_FREE, 1);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_ALLOC);
		send_op(dsa_pkg::OP_FREE, dsa_pkg::NO_INDEX);
		send_op(dsa_pkg::OP_FREE, 4);
		for (int s = 3; s >= 0; s--)
			send_op(dsa_pkg::OP_FREE, s);
		send_op(dsa_pkg::OP_FREE, 0);
	endtask

	task automatic test_frames_and_transients();
		load_config(4, 8, 4096, 64'hFFFF_FFFF_FFFF_F000, 64'h8000_0000_0000_0000);
		send_op(dsa_pkg::OP_BEGIN, 0, dsa_pkg::FRAMES_IN_FLIGHT);
		send_op(dsa_pkg::OP_BEGIN, 0, dsa_pkg::FRAMES_IN_FLIGHT - 1);
		send_op(dsa_pkg::OP_TRANSIENT, 0, 0, 0);
		send_op(dsa_pkg::OP_TRANSIENT, 0, 0, 8);
		send_op(dsa_pkg::OP_TRANSIENT, 0, 0, 1);
	endtask

	task automatic test_clear_and_unknown();
		send_op(OP_RESERVED_FIRST, dsa_pkg::NO_INDEX, 7, 8191);
		send_op(OP_RESERVED_LAST);
		send_op(dsa_pkg::OP_CLEAR);
		send_op(dsa_pkg::OP_ALLOC);
	endtask

	task automatic test_random_traffic(int count);
		request_t r;
		send_op(dsa_pkg::OP_CLEAR);
		repeat (count) begin
			make_random_request(r);
			send_request(r);
		end
	endtask

	task automatic test_backpressure();
		request_t r;
		int       saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		stall_request = BACKPRESSURE_CYCLES;
		repeat (40) begin
			make_random_request(r);
			send_request(r);
		end
		send_idle_pct = saved_idle;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request > 0) begin
				hold = stall_request;
				stall_request = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				flag_mismatch("unexpected beat", '0, m_tdata[79:16]);
			end else begin
				want = pending_grants.pop_front();
				// m_tdata: [15:0] index, [79:16] cpu, [143:80] gpu, [154:144] live count
				if (m_tuser !== want.status)
					flag_mismatch("status", want.status, m_tuser);
				if (m_tdata[15:0] !== want.index)
					flag_mismatch("granted_index", want.index, m_tdata[15:0]);
				if (m_tdata[79:16] !== want.cpu)
					flag_mismatch("cpu_address", want.cpu, m_tdata[79:16]);
				if (m_tdata[143:80] !== want.gpu)
					flag_mismatch("gpu_address", want.gpu, m_tdata[143:80]);
				if (m_tdata[154:144] !== want.live)
					flag_mismatch("persistent_live", want.live, m_tdata[154:144]);
			end
		end
	end

	// watchdog: end the run when no beat moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= dsa_pkg::OP_ALLOC;
		cfg_valid <= 1'b0;
		cfg_index <= dsa_pkg::REG_PCOUNT;
		cfg_data <= '0;
		send_idle_pct = 19;
		recv_idle_pct = 75;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_persistent_stack();
		test_frames_and_transients();
		test_clear_and_unknown();
		load_config(16, 40, 64, {$urandom, $urandom}, {$urandom, $urandom});
		test_random_traffic(600);

		send_idle_pct = 75;
		recv_idle_pct = 19;
		// out-of-range counts clamp to the maxima
		load_config(2047, 8191, 8191, '1, '1);
		test_random_traffic(600);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(1, 1, 0, '0, '0);
		test_random_traffic(300);
		load_config(MAX_PERSISTENT, dsa_pkg::MAX_TRANSIENT, 1, {$urandom, $urandom},
			{$urandom, $urandom});
		test_random_traffic(300);

		stop_offer();
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
